/* src/rth_pkg.sv */
// ----------------------------------------------------------------------------
// rth_pkg: shared constants for the ray/triangle hit test
// Digit width and latency of the pipelined signed multiplier.
// ----------------------------------------------------------------------------
package rth_pkg;

   localparam int DIGIT_BITS = 16;
   localparam int MUL_LAT    = 3;

endpackage

/* src/rth_mul.sv */
// ----------------------------------------------------------------------------
// rth_mul: pipelined signed multiplier
// Sign/magnitude form; 16x16 digit products, row sums, then the final sum and
// sign, each registered. One product per cycle.
// ----------------------------------------------------------------------------
module rth_mul #(
   parameter int A_BITS = 16,
   parameter int B_BITS = 16
) (
   input  logic                              clock,
   input  logic signed [A_BITS-1:0]          a_i,
   input  logic signed [B_BITS-1:0]          b_i,
   output logic signed [A_BITS+B_BITS-1:0]   p_o
);
   import rth_pkg::*;

   localparam int D  = DIGIT_BITS;
   localparam int NA = (A_BITS + D - 1) / D;
   localparam int NB = (B_BITS + D - 1) / D;
   localparam int AP = NA * D;
   localparam int BP = NB * D;
   localparam int RW = BP + D;
   localparam int TW = AP + BP;
   localparam int PB = A_BITS + B_BITS;

   logic [A_BITS-1:0] a_mag;
   logic [B_BITS-1:0] b_mag;
   logic [AP-1:0]     ua;
   logic [BP-1:0]     ub;

   logic [2*D-1:0] pp_ff [NA][NB];
   logic           neg1_ff;
   logic [RW-1:0]  row_in [NA];
   logic [RW-1:0]  row_ff [NA];
   logic           neg2_ff;
   logic [TW-1:0]  tot;
   logic [PB-1:0]  p_in;
   logic [PB-1:0]  p_ff;

   always_comb begin
      a_mag = a_i[A_BITS-1] ? A_BITS'(-a_i) : A_BITS'(a_i);
      b_mag = b_i[B_BITS-1] ? B_BITS'(-b_i) : B_BITS'(b_i);
      ua    = AP'(a_mag);
      ub    = BP'(b_mag);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NA; i++) begin
         for (int j = 0; j < NB; j++) begin
            pp_ff[i][j] <= ua[D*i +: D] * ub[D*j +: D];
         end
      end
      neg1_ff <= a_i[A_BITS-1] ^ b_i[B_BITS-1];
   end

   // sum each row of digit products
   always_comb begin
      for (int i = 0; i < NA; i++) begin
         row_in[i] = '0;
         for (int j = 0; j < NB; j++) begin
            row_in[i] = row_in[i] + (RW'(pp_ff[i][j]) << (D * j));
         end
      end
   end

   always_ff @(posedge clock) begin
      row_ff  <= row_in;
      neg2_ff <= neg1_ff;
   end

   always_comb begin
      tot = '0;
      for (int i = 0; i < NA; i++) begin
         tot = tot + (TW'(row_ff[i]) << (D * i));
      end
      p_in = neg2_ff ? PB'(-PB'(tot)) : PB'(tot);
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

   assign p_o = $signed(p_ff);

endmodule

/* src/ray_triangle_hit_test_top.sv */
// ----------------------------------------------------------------------------
// ray_triangle_hit_test_top: exact integer ray/triangle hit test
// Fully pipelined; one ray/triangle pair per clock while reset is low, one hit flag per pair.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive req_vertex_a/b/c, req_ray_origin and
//    req_ray_direction (x, y, z signed Q8.8 packed low to high) and raise
//    start. A transfer happens on every edge with start high and busy low;
//    busy is high only while reset is high, so a new pair may be offered
//    every cycle once reset is released.
//  - Response channel: rsp_valid pulses for one cycle with rsp_is_hit. The
//    receiver cannot stall; results leave in request order.
//  - Throughput: one pair per cycle once reset is released.
//  - The depth is set by four dependent multiply phases (normal; denominator,
//    numerator and edge normals; edge dot products; scaled edge sums), each a
//    pipelined multiplier plus one register for the sums.
//  - The coplanar xy-projection test runs in parallel with the normal phase.
//  - Reset clears the valid bits of every stage; data in flight is dropped.
// ----------------------------------------------------------------------------
module ray_triangle_hit_test_top #(
   parameter int COORD_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [3*COORD_BITS-1:0]   req_vertex_a,
   input  logic [3*COORD_BITS-1:0]   req_vertex_b,
   input  logic [3*COORD_BITS-1:0]   req_vertex_c,
   input  logic [3*COORD_BITS-1:0]   req_ray_origin,
   input  logic [3*COORD_BITS-1:0]   req_ray_direction,
   output logic                      rsp_valid,
   output logic                      rsp_is_hit
);
   import rth_pkg::*;

   localparam int W     = COORD_BITS;
   localparam int DW    = W + 1;            // coordinate differences
   localparam int NW    = 2 * DW + 1;       // normal components
   localparam int SW    = 3 * W + 6;        // denominator and numerator
   localparam int MW    = NW + DW + 1;      // n x edge
   localparam int AW2   = DW + MW + 2;      // edge dot products
   localparam int FW    = 2 * DW + 1;       // coplanar det, tn, sn
   localparam int PW    = SW + AW2 + 1;     // scaled edge sum
   localparam int L     = MUL_LAT;
   localparam int P1    = L + 1;
   localparam int P2    = 2 * L + 2;
   localparam int P3    = 3 * L + 3;
   localparam int P4    = 4 * L + 4;
   localparam int DEPTH = P4 + 1;

   typedef struct packed {
      logic                          valid;
      logic [2:0][DW-1:0]            d;
      logic [2:0][DW-1:0]            ao;
      logic [2:0][DW-1:0]            f;
      logic [2:0][2:0][DW-1:0]       e;
      logic [2:0][2:0][DW-1:0]       ov;
      logic [2:0][1:0][DW-1:0]       fb;
      logic [2:0][1:0][DW-1:0]       fc;
      logic [2:0][NW-1:0]            n;
      logic [SW-1:0]                 den;
      logic [SW-1:0]                 num;
      logic [2:0][2:0][MW-1:0]       m;
      logic [2:0][AW2-1:0]           pa;
      logic [2:0][AW2-1:0]           pb;
      logic                          flat;
      logic                          hit;
   } stage_type;

   stage_type line_ff [DEPTH];
   stage_type line_in [DEPTH];

   logic signed [W-1:0] vx [3][3];
   logic signed [W-1:0] ox [3];
   logic signed [W-1:0] dx [3];

   // multiplier outputs
   logic signed [2*DW-1:0]    n_p [3];
   logic signed [2*DW-1:0]    n_q [3];
   logic signed [2*DW-1:0]    fl_p [3][6];
   logic signed [NW+DW-1:0]   dn_p [3];
   logic signed [NW+DW-1:0]   nm_p [3];
   logic signed [NW+DW-1:0]   mp_p [3][3];
   logic signed [NW+DW-1:0]   mq_p [3][3];
   logic signed [DW+MW-1:0]   pa_p [3][3];
   logic signed [DW+MW-1:0]   pb_p [3][3];
   logic signed [SW+AW2-1:0]  sa_p [3];
   logic signed [SW+AW2-1:0]  sb_p [3];

   // phase results
   logic [NW-1:0]  n_cmb [3];
   logic [MW-1:0]  m_cmb [3][3];
   logic           flat_ok [3];
   logic           edge_ok [3];

   // hold off transfers while reset is high
   assign busy = reset;

   // unpack coordinates
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         vx[0][k] = $signed(req_vertex_a[k*W +: W]);
         vx[1][k] = $signed(req_vertex_b[k*W +: W]);
         vx[2][k] = $signed(req_vertex_c[k*W +: W]);
         ox[k]    = $signed(req_ray_origin[k*W +: W]);
         dx[k]    = $signed(req_ray_direction[k*W +: W]);
      end
   end

   genvar gi, gk;
   generate
      for (gi = 0; gi < 3; gi++) begin : g_lane
         localparam int GP = (gi + 1) % 3;
         localparam int GQ = (gi + 2) % 3;

         // normal n = e0 x f
         rth_mul #(.A_BITS(DW), .B_BITS(DW)) u_np (
            .clock(clock), .a_i(line_ff[0].e[0][GP]), .b_i(line_ff[0].f[GQ]),
            .p_o(n_p[gi]));
         rth_mul #(.A_BITS(DW), .B_BITS(DW)) u_nq (
            .clock(clock), .a_i(line_ff[0].e[0][GQ]), .b_i(line_ff[0].f[GP]),
            .p_o(n_q[gi]));
         assign n_cmb[gi] = NW'(n_p[gi]) - NW'(n_q[gi]);

         // coplanar edge products: det, tn, sn
         rth_mul #(.A_BITS(DW), .B_BITS(DW)) u_f0 (
            .clock(clock), .a_i(line_ff[0].d[0]), .b_i(line_ff[0].fb[gi][1]),
            .p_o(fl_p[gi][0]));
         rth_mul #(.A_BITS(DW), .B_BITS(DW)) u_f1 (
            .clock(clock), .a_i(line_ff[0].d[1]), .b_i(line_ff[0].fb[gi][0]),
            .p_o(fl_p[gi][1]));
         rth_mul #(.A_BITS(DW), .B_BITS(DW)) u_f2 (
            .clock(clock), .a_i(line_ff[0].fc[gi][0]), .b_i(line_ff[0].fb[gi][1]),
            .p_o(fl_p[gi][2]));
         rth_mul #(.A_BITS(DW), .B_BITS(DW)) u_f3 (
            .clock(clock), .a_i(line_ff[0].fc[gi][1]), .b_i(line_ff[0].fb[gi][0]),
            .p_o(fl_p[gi][3]));
         rth_mul #(.A_BITS(DW), .B_BITS(DW)) u_f4 (
            .clock(clock), .a_i(line_ff[0].d[0]), .b_i(line_ff[0].fc[gi][1]),
            .p_o(fl_p[gi][4]));
         rth_mul #(.A_BITS(DW), .B_BITS(DW)) u_f5 (
            .clock(clock), .a_i(line_ff[0].d[1]), .b_i(line_ff[0].fc[gi][0]),
            .p_o(fl_p[gi][5]));

         // denominator and numerator terms
         rth_mul #(.A_BITS(NW), .B_BITS(DW)) u_dn (
            .clock(clock), .a_i(line_ff[P1].n[gi]), .b_i(line_ff[P1].d[gi]),
            .p_o(dn_p[gi]));
         rth_mul #(.A_BITS(NW), .B_BITS(DW)) u_nm (
            .clock(clock), .a_i(line_ff[P1].n[gi]), .b_i(line_ff[P1].ao[gi]),
            .p_o(nm_p[gi]));

         // scaled edge sums
         rth_mul #(.A_BITS(SW), .B_BITS(AW2)) u_sa (
            .clock(clock), .a_i(line_ff[P3].den), .b_i(line_ff[P3].pa[gi]),
            .p_o(sa_p[gi]));
         rth_mul #(.A_BITS(SW), .B_BITS(AW2)) u_sb (
            .clock(clock), .a_i(line_ff[P3].num), .b_i(line_ff[P3].pb[gi]),
            .p_o(sb_p[gi]));

         for (gk = 0; gk < 3; gk++) begin : g_edge
            // edge normal m = n x e
            rth_mul #(.A_BITS(NW), .B_BITS(DW)) u_mp (
               .clock(clock), .a_i(line_ff[P1].n[GP]), .b_i(line_ff[P1].e[gk][GQ]),
               .p_o(mp_p[gk][gi]));
            rth_mul #(.A_BITS(NW), .B_BITS(DW)) u_mq (
               .clock(clock), .a_i(line_ff[P1].n[GQ]), .b_i(line_ff[P1].e[gk][GP]),
               .p_o(mq_p[gk][gi]));
            assign m_cmb[gk][gi] = MW'(mp_p[gk][gi]) - MW'(mq_p[gk][gi]);

            // (o - v) . m and d . m terms
            rth_mul #(.A_BITS(DW), .B_BITS(MW)) u_pa (
               .clock(clock), .a_i(line_ff[P2].ov[gk][gi]), .b_i(line_ff[P2].m[gk][gi]),
               .p_o(pa_p[gk][gi]));
            rth_mul #(.A_BITS(DW), .B_BITS(MW)) u_pb (
               .clock(clock), .a_i(line_ff[P2].d[gi]), .b_i(line_ff[P2].m[gk][gi]),
               .p_o(pb_p[gk][gi]));
         end
      end
   endgenerate

   // coplanar test per edge in the xy projection
   always_comb begin
      logic signed [FW-1:0] det;
      logic signed [FW-1:0] tn;
      logic signed [FW-1:0] sn;
      for (int k = 0; k < 3; k++) begin
         det = FW'(fl_p[k][0]) - FW'(fl_p[k][1]);
         tn  = FW'(fl_p[k][2]) - FW'(fl_p[k][3]);
         sn  = FW'(fl_p[k][4]) - FW'(fl_p[k][5]);
         if (det == '0) begin
            flat_ok[k] = 1'b0;
         end else if (det > 0) begin
            flat_ok[k] = (tn >= 0) && (sn >= 0) && (sn <= det);
         end else begin
            flat_ok[k] = (tn <= 0) && (sn <= 0) && (sn >= det);
         end
      end
   end

   // edge sums must be nonzero and share the sign of the denominator
   always_comb begin
      logic signed [PW-1:0] s;
      for (int k = 0; k < 3; k++) begin
         s = PW'(sa_p[k]) + PW'(sb_p[k]);
         edge_ok[k] = (s != '0) && ((s < 0) == line_ff[P4-1].den[SW-1]);
      end
   end

   always_comb begin
      logic signed [SW-1:0] den_s;
      logic signed [SW-1:0] num_s;

      // stage 0: differences from the request ports
      line_in[0]       = '0;
      line_in[0].valid = start && !busy;
      for (int i = 0; i < 3; i++) begin
         line_in[0].d[i]  = DW'(dx[i]);
         line_in[0].ao[i] = DW'(vx[0][i]) - DW'(ox[i]);
         line_in[0].f[i]  = DW'(vx[2][i]) - DW'(vx[0][i]);
      end
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            line_in[0].ov[k][i] = DW'(ox[i]) - DW'(vx[k][i]);
         end
      end
      line_in[0].e[0] = line_in[0].f;
      for (int i = 0; i < 3; i++) begin
         line_in[0].e[0][i] = DW'(vx[1][i]) - DW'(vx[0][i]);
         line_in[0].e[1][i] = DW'(vx[2][i]) - DW'(vx[1][i]);
         line_in[0].e[2][i] = DW'(vx[0][i]) - DW'(vx[2][i]);
      end
      for (int j = 0; j < 2; j++) begin
         line_in[0].fb[0][j] = DW'(vx[0][j]) - DW'(vx[1][j]);
         line_in[0].fb[1][j] = DW'(vx[1][j]) - DW'(vx[2][j]);
         line_in[0].fb[2][j] = DW'(vx[2][j]) - DW'(vx[0][j]);
         line_in[0].fc[0][j] = DW'(vx[0][j]) - DW'(ox[j]);
         line_in[0].fc[1][j] = DW'(vx[1][j]) - DW'(ox[j]);
         line_in[0].fc[2][j] = DW'(vx[2][j]) - DW'(ox[j]);
      end

      // advance the line
      for (int j = 1; j < DEPTH; j++) begin
         line_in[j] = line_ff[j-1];
      end

      // end of phase 1: normal and coplanar verdict
      for (int i = 0; i < 3; i++) begin
         line_in[P1].n[i] = n_cmb[i];
      end
      line_in[P1].flat = flat_ok[0] || flat_ok[1] || flat_ok[2];

      // end of phase 2: denominator, numerator, edge normals
      line_in[P2].den = SW'(dn_p[0]) + SW'(dn_p[1]) + SW'(dn_p[2]);
      line_in[P2].num = SW'(nm_p[0]) + SW'(nm_p[1]) + SW'(nm_p[2]);
      line_in[P2].m   = line_ff[P2-1].m;
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            line_in[P2].m[k][i] = m_cmb[k][i];
         end
      end

      // end of phase 3: edge dot products
      for (int k = 0; k < 3; k++) begin
         line_in[P3].pa[k] = AW2'(pa_p[k][0]) + AW2'(pa_p[k][1]) + AW2'(pa_p[k][2]);
         line_in[P3].pb[k] = AW2'(pb_p[k][0]) + AW2'(pb_p[k][1]) + AW2'(pb_p[k][2]);
      end

      // end of phase 4: final verdict
      den_s = $signed(line_ff[P4-1].den);
      num_s = $signed(line_ff[P4-1].num);
      if (den_s == '0) begin
         line_in[P4].hit = (num_s == '0) && line_ff[P4-1].flat;
      end else begin
         line_in[P4].hit = ((num_s == '0) || ((num_s < 0) == (den_s < 0)))
                           && edge_ok[0] && edge_ok[1] && edge_ok[2];
      end

      // drop everything in flight while reset is high
      if (reset) begin
         for (int j = 0; j < DEPTH; j++) begin
            line_in[j].valid = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j < DEPTH; j++) begin
         line_ff[j] <= line_in[j];
      end
   end

   assign rsp_valid  = line_ff[P4].valid;
   assign rsp_is_hit = line_ff[P4].hit;

endmodule

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the ray/triangle hit test
// Drives ray/triangle pairs through the command port, predicts each hit flag
// with exact wide integer arithmetic and compares every strobed response.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CB         = 16;
   localparam int W          = 3 * CB;
   localparam int STALL_MAX  = 2000;   // cycles with no transfer or response before giving up
   localparam int DRAIN_WAIT = 40;     // pipeline is 17 deep

   typedef logic signed [255:0] wide_type;

   logic          clock;
   logic          reset;
   logic          start;
   logic          busy;
   logic [W-1:0]  req_vertex_a;
   logic [W-1:0]  req_vertex_b;
   logic [W-1:0]  req_vertex_c;
   logic [W-1:0]  req_ray_origin;
   logic [W-1:0]  req_ray_direction;
   logic          rsp_valid;
   logic          rsp_is_hit;

   bit            expected_hits[$];
   int            mismatches;
   int            quiet_cycles;
   bit            idling_on;

   ray_triangle_hit_test_top #(.COORD_BITS(CB)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_vertex_a      (req_vertex_a),
      .req_vertex_b      (req_vertex_b),
      .req_vertex_c      (req_vertex_c),
      .req_ray_origin    (req_ray_origin),
      .req_ray_direction (req_ray_direction),
      .rsp_valid         (rsp_valid),
      .rsp_is_hit        (rsp_is_hit)
   );

   always begin
      clock = 1'b0; #5;
      clock = 1'b1; #5;
   end

   // ---------------------------------------------------------------------
   // Hit predictor
   // ---------------------------------------------------------------------
   function automatic void split_coords(input logic [W-1:0] raw, output longint v[3]);
      for (int k = 0; k < 3; k++) begin
         v[k] = longint'(signed'(raw[k*CB +: CB]));
      end
   endfunction

   // n.(E x Q) with Q = (o-V)*den + dir*num must be nonzero with the sign of den
   function automatic bit edge_inside(input wide_type n[3], input longint e[3],
                                      input longint o[3], input longint v[3],
                                      input longint d[3], input wide_type den,
                                      input wide_type num);
      wide_type q[3];
      wide_type ew[3];
      wide_type cr[3];
      wide_type s;
      wide_type ov;
      wide_type dv;
      for (int i = 0; i < 3; i++) begin
         ov = wide_type'(o[i] - v[i]);
         dv = wide_type'(d[i]);
         q[i] = ov * den + dv * num;
         ew[i] = wide_type'(e[i]);
      end
      for (int i = 0; i < 3; i++) begin
         cr[i] = ew[(i+1)%3] * q[(i+2)%3] - ew[(i+2)%3] * q[(i+1)%3];
      end
      s = n[0] * cr[0] + n[1] * cr[1] + n[2] * cr[2];
      return (s != 0) && ((s < 0) == (den < 0));
   endfunction

   // coplanar case: ray against edge va->vb in the xy projection
   function automatic bit flat_edge_hit(input longint va[3], input longint vb[3],
                                        input longint o[3], input longint d[3]);
      longint b1;
      longint c1;
      longint b2;
      longint c2;
      longint det;
      longint tn;
      longint sn;
      b1 = va[0] - vb[0];
      c1 = va[0] - o[0];
      b2 = va[1] - vb[1];
      c2 = va[1] - o[1];
      det = d[0] * b2 - d[1] * b1;
      tn = c1 * b2 - c2 * b1;
      sn = d[0] * c2 - d[1] * c1;
      if (det == 0) return 1'b0;
      if (det < 0) begin
         det = -det; tn = -tn; sn = -sn;
      end
      return tn >= 0 && sn >= 0 && sn <= det;
   endfunction

   function automatic bit ray_hits(input logic [W-1:0] ra, input logic [W-1:0] rb,
                                   input logic [W-1:0] rc, input logic [W-1:0] ro,
                                   input logic [W-1:0] rd);
      longint a[3], b[3], c[3], o[3], d[3];
      longint e0[3], e1[3], e2[3], f[3], nn[3];
      wide_type  n[3];
      wide_type  den;
      wide_type  num;
      wide_type  dw;
      wide_type  aw;
      split_coords(ra, a);
      split_coords(rb, b);
      split_coords(rc, c);
      split_coords(ro, o);
      split_coords(rd, d);
      for (int i = 0; i < 3; i++) begin
         e0[i] = b[i] - a[i];
         f[i]  = c[i] - a[i];
         e1[i] = c[i] - b[i];
         e2[i] = a[i] - c[i];
      end
      for (int i = 0; i < 3; i++) begin
         nn[i] = e0[(i+1)%3] * f[(i+2)%3] - e0[(i+2)%3] * f[(i+1)%3];
      end
      den = '0;
      num = '0;
      for (int i = 0; i < 3; i++) begin
         n[i] = wide_type'(nn[i]);
         dw = wide_type'(d[i]);
         aw = wide_type'(a[i] - o[i]);
         den = den + n[i] * dw;
         num = num + n[i] * aw;
      end
      if (den == 0) begin
         if (num != 0) return 1'b0;
         return flat_edge_hit(a, b, o, d) || flat_edge_hit(b, c, o, d) ||
                flat_edge_hit(c, a, o, d);
      end
      // reject t < 0 by sign alone
      if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
      return edge_inside(n, e0, o, a, d, den, num) &&
             edge_inside(n, e1, o, b, d, den, num) &&
             edge_inside(n, e2, o, c, d, den, num);
   endfunction

   // ---------------------------------------------------------------------
   // Transfer monitor, response checker and watchdog
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         quiet_cycles = quiet_cycles + 1;
         if (start && !busy) begin
            expected_hits.push_back(ray_hits(req_vertex_a, req_vertex_b, req_vertex_c,
                                              req_ray_origin, req_ray_direction));
            quiet_cycles = 0;
         end
         if (rsp_valid) begin
            quiet_cycles = 0;
            if (expected_hits.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual is_hit=%0b",
                        $time, rsp_is_hit);
               mismatches = mismatches + 1;
            end else begin
               if (rsp_is_hit !== expected_hits[0]) begin
                  $display("%0t: is_hit mismatch, expected %0b, actual %0b",
                           $time, expected_hits[0], rsp_is_hit);
                  mismatches = mismatches + 1;
               end
               void'(expected_hits.pop_front());
            end
         end
         if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: watchdog expired with %0d responses outstanding",
                     $time, expected_hits.size());
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   function automatic logic [W-1:0] pack_xyz(input int x, input int y, input int z);
      logic [CB-1:0] px;
      logic [CB-1:0] py;
      logic [CB-1:0] pz;
      px = x[CB-1:0];
      py = y[CB-1:0];
      pz = z[CB-1:0];
      return {pz, py, px};
   endfunction

   function automatic int rand_coord(input int lim);
      return $urandom_range(2 * lim) - lim;
   endfunction

   // optionally idle with start low, then hold the pair until the block takes it
   task automatic send_pair(input logic [W-1:0] a, input logic [W-1:0] b,
                            input logic [W-1:0] c, input logic [W-1:0] o,
                            input logic [W-1:0] d);
      int gap;
      if (idling_on && $urandom_range(3) == 0) begin
         gap = $urandom_range(19, 1);
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start             <= 1'b1;
      req_vertex_a      <= a;
      req_vertex_b      <= b;
      req_vertex_c      <= c;
      req_ray_origin    <= o;
      req_ray_direction <= d;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic go_quiet();
      start <= 1'b0;
   endtask

   task automatic wait_all_done();
      go_quiet();
      while (expected_hits.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_directed();
      logic [W-1:0] tri_a;
      logic [W-1:0] tri_b;
      logic [W-1:0] tri_c;
      tri_a = pack_xyz(0, 0, 0);
      tri_b = pack_xyz(256, 0, 0);
      tri_c = pack_xyz(0, 256, 0);
      // all zero: degenerate triangle, every projected edge parallel
      send_pair('0, '0, '0, '0, '0);
      // all ones and the signed extremes
      send_pair('1, '1, '1, '1, '1);
      send_pair(pack_xyz(32767, 32767, 32767), pack_xyz(-32768, 32767, -32768),
                pack_xyz(32767, -32768, -32768), pack_xyz(-32768, -32768, 32767),
                pack_xyz(32767, 32767, -32768));
      send_pair(pack_xyz(-32768, -32768, -32768), pack_xyz(32767, -32768, 0),
                pack_xyz(-32768, 32767, 0), pack_xyz(0, 0, 32767),
                pack_xyz(-32768, -32768, -32768));
      // plain hit straight down, and the same ray pointing away
      send_pair(tri_a, tri_b, tri_c, pack_xyz(64, 64, 256), pack_xyz(0, 0, -256));
      send_pair(tri_a, tri_b, tri_c, pack_xyz(64, 64, 256), pack_xyz(0, 0, 256));
      // origin in the plane with a crossing ray (t == 0)
      send_pair(tri_a, tri_b, tri_c, pack_xyz(64, 64, 0), pack_xyz(0, 0, -256));
      // boundary: hit point exactly on an edge and on a vertex is a miss
      send_pair(tri_a, tri_b, tri_c, pack_xyz(128, 0, 256), pack_xyz(0, 0, -256));
      send_pair(tri_a, tri_b, tri_c, pack_xyz(0, 0, 256), pack_xyz(0, 0, -256));
      // outside the triangle
      send_pair(tri_a, tri_b, tri_c, pack_xyz(300, 300, 256), pack_xyz(0, 0, -256));
      // reversed winding
      send_pair(tri_a, tri_c, tri_b, pack_xyz(64, 64, 256), pack_xyz(0, 0, -256));
      // parallel, off the plane
      send_pair(tri_a, tri_b, tri_c, pack_xyz(64, 64, 256), pack_xyz(256, 0, 0));
      // coplanar: ray in plane crossing, behind, leaving, and zero direction
      send_pair(tri_a, tri_b, tri_c, pack_xyz(-256, 64, 0), pack_xyz(256, 0, 0));
      send_pair(tri_a, tri_b, tri_c, pack_xyz(-256, 64, 0), pack_xyz(-256, 0, 0));
      send_pair(tri_a, tri_b, tri_c, pack_xyz(64, 64, 0), pack_xyz(256, 256, 0));
      send_pair(tri_a, tri_b, tri_c, pack_xyz(64, 64, 0), pack_xyz(0, 0, 0));
      // coplanar ray along an edge: that edge is parallel in projection
      send_pair(tri_a, tri_b, tri_c, pack_xyz(-256, 0, 0), pack_xyz(256, 0, 0));
      // degenerate collinear triangle
      send_pair(tri_a, tri_b, pack_xyz(512, 0, 0), pack_xyz(64, -64, 0),
                pack_xyz(0, 256, 0));
      // vertical triangle, coplanar check in a plane whose xy projection collapses
      send_pair(tri_a, tri_b, pack_xyz(0, 0, 256), pack_xyz(64, 0, -64),
                pack_xyz(0, 0, 256));
      wait_all_done();
   endtask

   // ray aimed at a weighted point of the triangle, so most pairs are hits
   task automatic test_aimed_rays(input int count);
      int v[3][3];
      int w[3];
      int p[3];
      int o[3];
      int lim;
      for (int it = 0; it < count; it++) begin
         lim = ($urandom_range(3) == 0) ? 8000 : 600;
         for (int k = 0; k < 3; k++)
            for (int j = 0; j < 3; j++) v[k][j] = rand_coord(lim);
         for (int k = 0; k < 3; k++) w[k] = $urandom_range(100, 1);
         // pull one weight to zero now and then to land on an edge
         if ($urandom_range(7) == 0) w[$urandom_range(2)] = 0;
         for (int j = 0; j < 3; j++) begin
            p[j] = (w[0] * v[0][j] + w[1] * v[1][j] + w[2] * v[2][j]) /
                   (w[0] + w[1] + w[2]);
            o[j] = rand_coord(lim);
         end
         send_pair(pack_xyz(v[0][0], v[0][1], v[0][2]),
                   pack_xyz(v[1][0], v[1][1], v[1][2]),
                   pack_xyz(v[2][0], v[2][1], v[2][2]),
                   pack_xyz(o[0], o[1], o[2]),
                   ($urandom_range(5) == 0) ?
                      pack_xyz(o[0] - p[0], o[1] - p[1], o[2] - p[2]) :
                      pack_xyz(p[0] - o[0], p[1] - o[1], p[2] - o[2]));
      end
   endtask

   // everything in one plane z = h, small values so parallels and zeros show up
   task automatic test_coplanar(input int count);
      int h;
      int lim;
      for (int it = 0; it < count; it++) begin
         h = rand_coord(20);
         lim = ($urandom_range(4) == 0) ? 4000 : 12;
         send_pair(pack_xyz(rand_coord(lim), rand_coord(lim), h),
                   pack_xyz(rand_coord(lim), rand_coord(lim), h),
                   pack_xyz(rand_coord(lim), rand_coord(lim), h),
                   pack_xyz(rand_coord(lim), rand_coord(lim), h),
                   pack_xyz(rand_coord(lim), rand_coord(lim), 0));
      end
   endtask

   // raw random words: every bit of every field toggles
   task automatic test_raw_noise(input int count);
      logic [W-1:0] f[5];
      for (int it = 0; it < count; it++) begin
         for (int k = 0; k < 5; k++) f[k] = W'({$urandom(), $urandom()});
         send_pair(f[0], f[1], f[2], f[3], f[4]);
      end
   endtask

   initial begin
      mismatches        = 0;
      quiet_cycles      = 0;
      idling_on         = 1'b0;
      reset             = 1'b1;
      start             = 1'b0;
      req_vertex_a      = '0;
      req_vertex_b      = '0;
      req_vertex_c      = '0;
      req_ray_origin    = '0;
      req_ray_direction = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      idling_on = 1'b1;
      test_aimed_rays(700);
      // sender pause: let the pipeline empty before the next batch
      wait_all_done();
      test_coplanar(350);
      test_raw_noise(300);
      // closing stretch with back-to-back transfers
      idling_on = 1'b0;
      test_aimed_rays(200);
      test_coplanar(50);
      test_raw_noise(50);
      wait_all_done();
      repeat (DRAIN_WAIT) @(posedge clock);

      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* sim.f */
src/rth_pkg.sv
src/rth_mul.sv
src/ray_triangle_hit_test_top.sv
bench/tb_top.sv
